@@ src/slist_pkg.sv @@
// Shared types and codes for the sequential list engine.
`default_nettype none

package slist_pkg;

	// Command codes carried in the command field
	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_READ   = 3'd3,
		CMD_FIND   = 3'd4,
		CMD_SORTED = 3'd5
	} cmd_code_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_FETCH,
		S_TAKE,
		S_SHIFT_DN,
		S_SCAN,
		S_SHIFT_UP,
		S_PLACE,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load;       // capture the incoming item
		logic    seek_pos;   // idx and ptr to position - 1
		logic    ptr_count;  // ptr to element count (overrides seek_pos)
		logic    ptr_zero;   // ptr to zero
		logic    rd_ptr;     // read entry at ptr, advance ptr
		logic    take_rv;    // latch read data as result value
		logic    step_up;    // one step of the upward shift
		logic    step_dn;    // one step of the downward shift
		logic    step_scan;  // one step of the linear scan
		logic    scan_fin;   // close the scan: found position or insert index
		logic    place;      // write new value at idx, bump count
		logic    dec_count;  // drop one element from the count
		logic    clr_count;  // empty the list
		logic    set_st;     // load status register
		status_t st;
		logic    publish;    // move result into the output register
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       full;
		logic       empty;
		logic       pos_bad;
		logic       ins_bad;
		logic       up_more;
		logic       lt_cnt;
		logic       wr_pend;
		logic       chk;
		logic       hit;
		logic       out_free;
	} dp_flags_t;

endpackage

`default_nettype wire

@@ src/slist_ctrl.sv @@
// Controller state machine for the sequential list engine.
`default_nettype none

module slist_ctrl
	import slist_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire dp_flags_t flags,
	output ctl_t           ctl
);

	state_t state_q;
	state_t state_nxt;
	logic   scan_done;

	assign scan_done = flags.hit || (!flags.lt_cnt && !flags.chk);
	assign cmd_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_nxt = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (flags.cmd)
					CMD_INSERT: begin
						if (flags.full || flags.ins_bad) state_nxt = S_FINISH;
						else state_nxt = S_SHIFT_UP;
					end
					CMD_DELETE, CMD_READ: begin
						if (flags.empty || flags.pos_bad) state_nxt = S_FINISH;
						else state_nxt = S_FETCH;
					end
					CMD_FIND: state_nxt = S_SCAN;
					CMD_SORTED: begin
						if (flags.full) state_nxt = S_FINISH;
						else state_nxt = S_SCAN;
					end
					default: state_nxt = S_FINISH;
				endcase
			end
			S_FETCH: state_nxt = S_TAKE;
			S_TAKE: begin
				if (flags.cmd == CMD_DELETE) state_nxt = S_SHIFT_DN;
				else state_nxt = S_FINISH;
			end
			S_SHIFT_DN: begin
				if (!flags.lt_cnt && !flags.wr_pend) state_nxt = S_FINISH;
			end
			S_SCAN: begin
				if (scan_done) begin
					if (flags.cmd == CMD_FIND) state_nxt = S_FINISH;
					else state_nxt = S_SHIFT_UP;
				end
			end
			S_SHIFT_UP: begin
				if (!flags.up_more && !flags.wr_pend) state_nxt = S_PLACE;
			end
			S_PLACE: state_nxt = S_FINISH;
			S_FINISH: begin
				if (flags.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl = '0;
		ctl.st = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = cmd_valid;
			end
			S_DISPATCH: begin
				unique case (flags.cmd)
					CMD_CLEAR: ctl.clr_count = 1'b1;
					CMD_INSERT: begin
						if (flags.full) begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_FULL;
						end else if (flags.ins_bad) begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_BADPOS;
						end else begin
							ctl.seek_pos  = 1'b1;
							ctl.ptr_count = 1'b1;
						end
					end
					CMD_DELETE, CMD_READ: begin
						if (flags.empty) begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_EMPTY;
						end else if (flags.pos_bad) begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_BADPOS;
						end else begin
							ctl.seek_pos = 1'b1;
						end
					end
					CMD_FIND: ctl.ptr_zero = 1'b1;
					CMD_SORTED: begin
						if (flags.full) begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_FULL;
						end else begin
							ctl.ptr_zero = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_FETCH: ctl.rd_ptr = 1'b1;
			S_TAKE: ctl.take_rv = 1'b1;
			S_SHIFT_DN: begin
				if (flags.lt_cnt || flags.wr_pend) ctl.step_dn = 1'b1;
				else ctl.dec_count = 1'b1;
			end
			S_SCAN: begin
				if (scan_done) begin
					ctl.scan_fin = 1'b1;
					if (flags.cmd == CMD_FIND) begin
						ctl.set_st = 1'b1;
						ctl.st     = flags.hit ? ST_OK : ST_NOTFOUND;
					end else begin
						ctl.ptr_count = 1'b1;
					end
				end else begin
					ctl.step_scan = 1'b1;
				end
			end
			S_SHIFT_UP: begin
				if (flags.up_more || flags.wr_pend) ctl.step_up = 1'b1;
			end
			S_PLACE: ctl.place = 1'b1;
			S_FINISH: ctl.publish = flags.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ src/slist_dp.sv @@
// Datapath of the sequential list engine: element memory, pointers, result registers.
`default_nettype none

module slist_dp
	import slist_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctl_t               ctl,
	output dp_flags_t               flags,
	input  wire logic [2:0]         command,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [2:0]              status,
	output logic signed [31:0]      result_value,
	output logic [7:0]              found_position,
	output logic [7:0]              list_count
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

	logic [31:0]        elem_mem_q [CAPACITY];
	logic [31:0]        rdata_s1;

	logic [2:0]         cmd_q;
	logic [7:0]         pos_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      chk_idx_q;
	logic [AW-1:0]      wa_q;
	logic               wr_pend_q;
	logic               chk_q;
	status_t            st_q;
	logic signed [31:0] rv_q;
	logic [7:0]         fp_q;
	logic               out_valid_q;

	logic [CMPW-1:0]    pos_ext;
	logic [CMPW-1:0]    cnt_ext;
	logic [CW-1:0]      pos_m1;
	logic [CW-1:0]      ptr_dec;
	logic               up_more;
	logic               lt_cnt;
	logic               cmp;
	logic               hit;
	logic               up_issue;
	logic               dn_issue;
	logic               scan_issue;
	logic               re;
	logic [CW-1:0]      ra;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic               out_free;

	assign pos_ext = CMPW'(pos_q);
	assign cnt_ext = CMPW'(count_q);
	assign pos_m1  = CW'(pos_ext - CMPW'(1));
	assign ptr_dec = ptr_q - CW'(1);
	assign up_more = (ptr_q > idx_q);
	assign lt_cnt  = (ptr_q < count_q);

	// Find matches equal values, sorted insert stops at the first element >= value
	assign cmp = (cmd_q == CMD_FIND) ? (rdata_s1 == val_q)
	                                 : ($signed(rdata_s1) >= val_q);
	assign hit = chk_q && cmp;

	assign up_issue   = ctl.step_up && up_more;
	assign dn_issue   = ctl.step_dn && lt_cnt;
	assign scan_issue = ctl.step_scan && lt_cnt && !hit;
	assign re         = ctl.rd_ptr || up_issue || dn_issue || scan_issue;
	assign ra         = ctl.step_up ? ptr_dec : ptr_q;

	assign we    = ctl.place || wr_pend_q;
	assign waddr = ctl.place ? idx_q[AW-1:0] : wa_q;
	assign wdata = ctl.place ? val_q : rdata_s1;

	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		flags          = '0;
		flags.cmd      = cmd_q;
		flags.full     = (cnt_ext == CMPW'(CAPACITY));
		flags.empty    = (count_q == '0);
		flags.pos_bad  = (pos_q == 8'd0) || (pos_ext > cnt_ext);
		flags.ins_bad  = (pos_q == 8'd0) || (pos_ext > cnt_ext + CMPW'(1));
		flags.up_more  = up_more;
		flags.lt_cnt   = lt_cnt;
		flags.wr_pend  = wr_pend_q;
		flags.chk      = chk_q;
		flags.hit      = hit;
		flags.out_free = out_free;
	end

	// Element memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) elem_mem_q[waddr] <= wdata;
		if (re) rdata_s1 <= elem_mem_q[ra[AW-1:0]];
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= value;
			st_q  <= ST_OK;
			rv_q  <= '0;
			fp_q  <= '0;
		end
		if (ctl.set_st) st_q <= ctl.st;
		if (ctl.take_rv) rv_q <= $signed(rdata_s1);

		if (ctl.ptr_count) ptr_q <= count_q;
		else if (ctl.seek_pos) ptr_q <= pos_m1;
		else if (ctl.ptr_zero) ptr_q <= '0;
		else if (up_issue) ptr_q <= ptr_dec;
		else if (ctl.rd_ptr || dn_issue || scan_issue) ptr_q <= ptr_q + CW'(1);

		if (ctl.seek_pos) idx_q <= pos_m1;
		else if (ctl.scan_fin && (cmd_q != CMD_FIND)) idx_q <= hit ? chk_idx_q : count_q;

		if (ctl.scan_fin && (cmd_q == CMD_FIND) && hit) begin
			fp_q <= 8'(CMPW'(chk_idx_q) + CMPW'(1));
		end

		if (scan_issue) chk_idx_q <= ptr_q;
		if (up_issue) wa_q <= ptr_q[AW-1:0];
		else if (dn_issue) wa_q <= ptr_dec[AW-1:0];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wr_pend_q   <= 1'b0;
			chk_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_count) count_q <= '0;
			else if (ctl.place) count_q <= count_q + CW'(1);
			else if (ctl.dec_count) count_q <= count_q - CW'(1);

			wr_pend_q <= up_issue || dn_issue;
			chk_q     <= scan_issue;

			if (ctl.publish) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			status         <= st_q;
			result_value   <= rv_q;
			found_position <= fp_q;
			list_count     <= 8'(count_q);
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

@@ src/sequential_list_engine_top.sv @@
// Top level of the sequential list engine: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  cmd     | in        | cmd_valid / cmd_stall | command, position, value
//  rsp     | out       | rsp_valid / rsp_stall | status, result_value, found_position,
//          |           |                       | list_count
//
// One item at a time. Clear, errors and unused codes touch no entry, and read fetches
// one; delete at position p shifts the entries after p down by one; insert at p shifts
// the entries from p onward up by one (no shift when appending at count + 1); find scans
// from the first entry to the match or the end; sorted insert scans for the first
// element >= value, then shifts up as insert does. Every walk is made by the element
// memory, one entry per cycle through its single read port.
// Reset empties the list; the element memory itself is not cleared.
// A new item is taken while the previous result still waits in the output register;
// its result is held back until that register is free.
`default_nettype none

module sequential_list_engine_top
	import slist_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [2:0]         command,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [2:0]              status,
	output logic signed [31:0]      result_value,
	output logic [7:0]              found_position,
	output logic [7:0]              list_count
);

	ctl_t      ctl;
	dp_flags_t flags;

	// Sequencer: decides the memory walk for each item
	slist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.flags     (flags),
		.ctl       (ctl)
	);

	// Element store, pointers and the result register
	slist_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.flags          (flags),
		.command        (command),
		.position       (position),
		.value          (value),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.result_value   (result_value),
		.found_position (found_position),
		.list_count     (list_count)
	);

endmodule

`default_nettype wire

@@ src/slist_chk.sv @@
// Port checker for the sequential list engine, bound to the top level.
`default_nettype none

module slist_chk
	import slist_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_stall,
	input wire logic               rsp_valid,
	input wire logic               rsp_stall,
	input wire logic [2:0]         status,
	input wire logic signed [31:0] result_value,
	input wire logic [7:0]         found_position,
	input wire logic [7:0]         list_count
);

	localparam logic [7:0] CAP_LOW = 8'(CAPACITY);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
			&& $stable(result_value) && $stable(found_position) && $stable(list_count))
		else $error("stalled result changed");

	// A full report only comes with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL) |-> (list_count == CAP_LOW))
		else $error("full status with list not full");

	// An empty report only comes with an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_EMPTY) |-> (list_count == 8'd0))
		else $error("empty status with elements present");

	// A found position only comes with a good status and no value
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (found_position != 8'd0) |-> (status == ST_OK) && (result_value == 0))
		else $error("found position on a failed or value-bearing result");

	// Stall is raised once a command is taken in, so no second item is taken while busy
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second item taken while busy");

endmodule

bind sequential_list_engine_top slist_chk #(
	.CAPACITY (CAPACITY)
) u_slist_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd_valid),
	.cmd_stall      (cmd_stall),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.status         (status),
	.result_value   (result_value),
	.found_position (found_position),
	.list_count     (list_count)
);

`default_nettype wire
